@@ rtl/scpr_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Spectrum column renderer package
// Matrix geometry, derived widths, palette codes, constant hue and value
// tables and the structs passed between the renderer modules.
// ----------------------------------------------------------------------------
package scpr_pkg;

  localparam int COLUMNS = 16;
  localparam int ROWS    = 16;

  localparam int COL_MAX = COLUMNS - 1;
  localparam int ROW_MAX = ROWS - 1;

  localparam int COL_W = $clog2(COLUMNS);
  localparam int ROW_W = $clog2(ROWS);
  localparam int HGT_W = $clog2(ROWS + 1);
  localparam int AX_W  = (COL_W > ROW_W) ? COL_W : ROW_W;
  localparam int LIN_W = $clog2(ROWS * COLUMNS);

  localparam int RAINBOW_SPAN   = 256;
  localparam int GRAD_VALUE_LOW = 60;
  localparam int FULL_VALUE     = 255;

  // Two-hue gradient: axis * |end - start| divided by the axis maximum.
  localparam int P_W      = AX_W + 8;
  localparam int RECIP_SH = P_W;
  localparam int M_W      = RECIP_SH + 1;
  localparam logic [M_W-1:0] RECIP_X = M_W'((1 << RECIP_SH) / COL_MAX);
  localparam logic [M_W-1:0] RECIP_Y = M_W'((1 << RECIP_SH) / ROW_MAX);

  // The animation step is time / 20, taken as (time >> 2) / 5.
  localparam int             TIME_W    = 32;
  localparam int             DIV5_IN_W = TIME_W - 2;
  localparam int             DIV5_PR_W = DIV5_IN_W + 32;
  localparam int             DIV5_SH   = 34;
  localparam logic [31:0]    DIV5_MUL  = 32'hCCCC_CCCD;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_PALETTE_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FLAT_HUE     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GRAD_START   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GRAD_END     = 2'd3;

  localparam logic [3:0] PM_RAINBOW_H = 4'd0;
  localparam logic [3:0] PM_RAINBOW_V = 4'd1;
  localparam logic [3:0] PM_ANIM_H    = 4'd2;
  localparam logic [3:0] PM_ANIM_V    = 4'd3;
  localparam logic [3:0] PM_SOLID     = 4'd4;
  localparam logic [3:0] PM_GRAD1_H   = 4'd5;
  localparam logic [3:0] PM_GRAD1_V   = 4'd6;
  localparam logic [3:0] PM_GRAD2_H   = 4'd7;
  localparam logic [3:0] PM_GRAD2_V   = 4'd8;

  localparam logic [3:0] RST_PALETTE_MODE = PM_RAINBOW_H;
  localparam logic [7:0] RST_FLAT_HUE     = 8'd224;
  localparam logic [7:0] RST_GRAD_START   = 8'd224;
  localparam logic [7:0] RST_GRAD_END     = 8'd96;

  typedef logic [COLUMNS-1:0][7:0] tab_x_t;
  typedef logic [ROWS-1:0][7:0]    tab_y_t;

  typedef struct packed {
    logic [3:0] mode;
    logic [7:0] flat_hue;
    logic [7:0] grad_start;
    logic [7:0] grad_end;
  } cfg_t;

  typedef struct packed {
    logic             valid;
    logic [ROW_W-1:0] y;
    logic [COL_W-1:0] x;
    logic [HGT_W-1:0] h;
    logic [7:0]       toff;
    logic             last;
  } row_tok_t;

  function automatic tab_x_t rainbow_tab_x();
    tab_x_t tab;
    for (int i = 0; i < COLUMNS; i++) begin
      tab[i] = 8'((i * RAINBOW_SPAN) / COLUMNS);
    end
    return tab;
  endfunction

  function automatic tab_y_t rainbow_tab_y();
    tab_y_t tab;
    for (int i = 0; i < ROWS; i++) begin
      tab[i] = 8'((i * RAINBOW_SPAN) / ROWS);
    end
    return tab;
  endfunction

  function automatic tab_x_t value_tab_x();
    tab_x_t tab;
    for (int i = 0; i < COLUMNS; i++) begin
      tab[i] = 8'((i * (FULL_VALUE - GRAD_VALUE_LOW)) / COL_MAX + GRAD_VALUE_LOW);
    end
    return tab;
  endfunction

  function automatic tab_y_t value_tab_y();
    tab_y_t tab;
    for (int i = 0; i < ROWS; i++) begin
      tab[i] = 8'((i * (FULL_VALUE - GRAD_VALUE_LOW)) / ROW_MAX + GRAD_VALUE_LOW);
    end
    return tab;
  endfunction

  localparam tab_x_t RAINBOW_X = rainbow_tab_x();
  localparam tab_y_t RAINBOW_Y = rainbow_tab_y();
  localparam tab_x_t VALUE_X   = value_tab_x();
  localparam tab_y_t VALUE_Y   = value_tab_y();

endpackage
`default_nettype wire

@@ rtl/spectrum_column_palette_renderer_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Spectrum column palette renderer
// Renders one spectrum bar column of a serpentine LED matrix: one beat per
// row, bottom to top, with strip index, palette hue and value.
// ----------------------------------------------------------------------------
// A taken column passes the sequencer's waiting and row registers and the
// three color stages before its first row beat. Throughput, set by the row
// sequencer: ROWS row beats per column at one per cycle while out_stall is
// low. One more column beat waits while the current is rendered; later stall.
// Reset: synchronous active-low rst_n empties the pipeline and loads the
// register defaults; no clearing pass.
module spectrum_column_palette_renderer_core (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [scpr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [scpr_pkg::CFG_DAT_W-1:0]  cfg_wdata,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [3:0]                      in_column,
  input  wire logic [7:0]                      in_bar_height,
  input  wire logic [scpr_pkg::TIME_W-1:0]     in_time_ms,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [7:0]                           out_led_index,
  output logic [7:0]                           out_hue,
  output logic [7:0]                           out_brightness,
  output logic                                 out_lit,
  output logic                                 out_last
);

  scpr_pkg::cfg_t     cfg;
  scpr_pkg::row_tok_t tok;
  logic               tok_ready;

  scpr_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  scpr_seq u_seq (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_column     (in_column),
    .in_bar_height (in_bar_height),
    .in_time_ms    (in_time_ms),
    .tok_ready     (tok_ready),
    .tok           (tok)
  );

  scpr_color u_color (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg),
    .tok            (tok),
    .tok_ready      (tok_ready),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_led_index  (out_led_index),
    .out_hue        (out_hue),
    .out_brightness (out_brightness),
    .out_lit        (out_lit),
    .out_last       (out_last)
  );

  // An unlit row carries neither hue nor value.
  a_unlit_dark: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_lit |-> out_hue == 8'd0 && out_brightness == 8'd0)
    else $error("unlit row with nonzero hue or value");

  // Rows of one column follow each other without a gap.
  a_rows_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last |=> out_valid)
    else $error("gap inside a column");

  // Once a row is dark, every row above it in the column is dark too.
  a_lit_monotone: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last && !out_lit |=> !out_lit)
    else $error("lit row above a dark row");

  // After the top row is taken, the sequencer is idle or starts again at the bottom row.
  a_seq_drains: assert property (@(posedge clk) disable iff (!rst_n)
    tok.valid && tok_ready && tok.last |=> !tok.valid || tok.y == '0)
    else $error("column did not restart at the bottom row");

endmodule
`default_nettype wire

@@ rtl/scpr_cfg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Spectrum column renderer configuration registers
// Palette mode and the three palette hues, written through a plain write port.
// ----------------------------------------------------------------------------
module scpr_cfg (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [scpr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [scpr_pkg::CFG_DAT_W-1:0]  cfg_wdata,
  output scpr_pkg::cfg_t                       cfg
);

  scpr_pkg::cfg_t cfg_r;
  scpr_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        scpr_pkg::REG_PALETTE_MODE: cfg_nxt.mode       = cfg_wdata[3:0];
        scpr_pkg::REG_FLAT_HUE:     cfg_nxt.flat_hue   = cfg_wdata;
        scpr_pkg::REG_GRAD_START:   cfg_nxt.grad_start = cfg_wdata;
        scpr_pkg::REG_GRAD_END:     cfg_nxt.grad_end   = cfg_wdata;
        default:                    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode       <= scpr_pkg::RST_PALETTE_MODE;
      cfg_r.flat_hue   <= scpr_pkg::RST_FLAT_HUE;
      cfg_r.grad_start <= scpr_pkg::RST_GRAD_START;
      cfg_r.grad_end   <= scpr_pkg::RST_GRAD_END;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

@@ rtl/scpr_seq.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Spectrum column renderer row sequencer
// Holds one waiting column beat and the column being rendered, and issues one
// row token per cycle while tok_ready is high, bottom row to top row.
// ----------------------------------------------------------------------------
module scpr_seq (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [3:0]                    in_column,
  input  wire logic [7:0]                    in_bar_height,
  input  wire logic [scpr_pkg::TIME_W-1:0]   in_time_ms,
  input  wire logic                          tok_ready,
  output scpr_pkg::row_tok_t                 tok
);

  logic                          a_valid_r, a_valid_nxt;
  logic [3:0]                    a_col_r;
  logic [7:0]                    a_hgt_r;
  logic [scpr_pkg::TIME_W-1:0]   a_time_r;

  logic                          b_valid_r, b_valid_nxt;
  logic [scpr_pkg::ROW_W-1:0]    b_row_r, b_row_nxt;
  logic [scpr_pkg::COL_W-1:0]    b_x_r;
  logic [scpr_pkg::HGT_W-1:0]    b_h_r;
  logic [7:0]                    b_toff_r;

  logic                          in_take;
  logic                          b_take;
  logic                          b_done;
  logic                          b_load;
  logic [scpr_pkg::COL_W-1:0]    x_clamp;
  logic [scpr_pkg::HGT_W-1:0]    h_clamp;
  logic [scpr_pkg::DIV5_PR_W-1:0] div5_prod;

  assign b_take   = b_valid_r && tok_ready;
  assign b_done   = b_take && (b_row_r == scpr_pkg::ROW_W'(scpr_pkg::ROW_MAX));
  assign b_load   = a_valid_r && (!b_valid_r || b_done);
  assign in_stall = a_valid_r && !b_load;
  assign in_take  = in_valid && !in_stall;

  assign x_clamp = (32'(a_col_r) > 32'(scpr_pkg::COL_MAX)) ?
                   scpr_pkg::COL_W'(scpr_pkg::COL_MAX) : scpr_pkg::COL_W'(a_col_r);
  assign h_clamp = (32'(a_hgt_r) > 32'(scpr_pkg::ROWS)) ?
                   scpr_pkg::HGT_W'(scpr_pkg::ROWS) : scpr_pkg::HGT_W'(a_hgt_r);

  assign div5_prod = scpr_pkg::DIV5_PR_W'(a_time_r[scpr_pkg::TIME_W-1:2]) *
                     scpr_pkg::DIV5_PR_W'(scpr_pkg::DIV5_MUL);

  always_comb begin
    a_valid_nxt = a_valid_r;
    if (in_take) begin
      a_valid_nxt = 1'b1;
    end else if (b_load) begin
      a_valid_nxt = 1'b0;
    end
    b_valid_nxt = b_valid_r;
    b_row_nxt   = b_row_r;
    if (b_load) begin
      b_valid_nxt = 1'b1;
      b_row_nxt   = '0;
    end else if (b_done) begin
      b_valid_nxt = 1'b0;
    end else if (b_take) begin
      b_row_nxt = b_row_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
      b_row_r   <= '0;
    end else begin
      a_valid_r <= a_valid_nxt;
      b_valid_r <= b_valid_nxt;
      b_row_r   <= b_row_nxt;
    end
    if (in_take) begin
      a_col_r  <= in_column;
      a_hgt_r  <= in_bar_height;
      a_time_r <= in_time_ms;
    end
    if (b_load) begin
      b_x_r    <= x_clamp;
      b_h_r    <= h_clamp;
      b_toff_r <= div5_prod[scpr_pkg::DIV5_SH +: 8];
    end
  end

  always_comb begin
    tok.valid = b_valid_r;
    tok.y     = b_row_r;
    tok.x     = b_x_r;
    tok.h     = b_h_r;
    tok.toff  = b_toff_r;
    tok.last  = (b_row_r == scpr_pkg::ROW_W'(scpr_pkg::ROW_MAX));
  end

endmodule
`default_nettype wire

@@ rtl/scpr_color.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Spectrum column renderer color pipeline
// Three register stages per row: strip index and table lookups, reciprocal
// division for the two-hue gradient, then palette selection into the output.
// ----------------------------------------------------------------------------
module scpr_color (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire scpr_pkg::cfg_t     cfg,
  input  wire scpr_pkg::row_tok_t tok,
  output logic                    tok_ready,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [7:0]              out_led_index,
  output logic [7:0]              out_hue,
  output logic [7:0]              out_brightness,
  output logic                    out_lit,
  output logic                    out_last
);

  localparam int QM_W = scpr_pkg::P_W + scpr_pkg::M_W;
  localparam int QD_W = 2 * scpr_pkg::P_W;

  logic adv;
  logic vert;

  // First stage inputs.
  logic [scpr_pkg::AX_W-1:0]  axis;
  logic [scpr_pkg::COL_W-1:0] x_strip;
  logic [scpr_pkg::LIN_W-1:0] lin_idx;
  logic [8:0]                 diff;
  logic [8:0]                 diff_neg;
  logic [7:0]                 diff_mag;

  logic                       r1_valid_r, r1_valid_nxt;
  logic                       r1_lit_r, r1_last_r, r1_neg_r;
  logic [7:0]                 r1_idx_r, r1_rain_r, r1_toff_r, r1_gval_r;
  logic [scpr_pkg::P_W-1:0]   r1_p_r;

  logic [QM_W-1:0]            qm;
  logic [scpr_pkg::M_W-1:0]   recip;

  logic                       r2_valid_r, r2_valid_nxt;
  logic                       r2_lit_r, r2_last_r, r2_neg_r;
  logic [7:0]                 r2_idx_r, r2_rain_r, r2_toff_r, r2_gval_r;
  logic [scpr_pkg::P_W-1:0]   r2_p_r, r2_q0_r;

  logic [scpr_pkg::P_W-1:0]   dsel;
  logic [QD_W-1:0]            qd;
  logic [scpr_pkg::P_W-1:0]   rem;
  logic [scpr_pkg::P_W-1:0]   quot;
  logic [7:0]                 grad_hue;
  logic [7:0]                 hue_sel, val_sel;

  logic                       out_valid_r, out_valid_nxt;
  logic [7:0]                 out_idx_r, out_hue_r, out_val_r;
  logic                       out_lit_r, out_last_r;

  assign adv       = !out_valid_r || !out_stall;
  assign tok_ready = adv;

  always_comb begin
    vert = cfg.mode inside {scpr_pkg::PM_RAINBOW_V, scpr_pkg::PM_ANIM_V,
                            scpr_pkg::PM_GRAD1_V, scpr_pkg::PM_GRAD2_V};
  end

  assign axis    = vert ? scpr_pkg::AX_W'(tok.y) : scpr_pkg::AX_W'(tok.x);
  assign x_strip = tok.y[0] ? (scpr_pkg::COL_W'(scpr_pkg::COL_MAX) - tok.x) : tok.x;
  assign lin_idx = scpr_pkg::LIN_W'(tok.y) * scpr_pkg::LIN_W'(scpr_pkg::COLUMNS) +
                   scpr_pkg::LIN_W'(x_strip);
  assign diff     = {1'b0, cfg.grad_end} - {1'b0, cfg.grad_start};
  assign diff_neg = -diff;
  assign diff_mag = diff[8] ? diff_neg[7:0] : diff[7:0];

  assign recip = vert ? scpr_pkg::RECIP_Y : scpr_pkg::RECIP_X;
  assign qm    = QM_W'(r1_p_r) * QM_W'(recip);

  // The reciprocal estimate is low by at most one; a single correction fixes it.
  assign dsel     = vert ? scpr_pkg::P_W'(scpr_pkg::ROW_MAX) :
                           scpr_pkg::P_W'(scpr_pkg::COL_MAX);
  assign qd       = QD_W'(r2_q0_r) * QD_W'(dsel);
  assign rem      = scpr_pkg::P_W'(QD_W'(r2_p_r) - qd);
  assign quot     = r2_q0_r + scpr_pkg::P_W'(rem >= dsel);
  assign grad_hue = r2_neg_r ? (cfg.grad_start - quot[7:0]) :
                               (cfg.grad_start + quot[7:0]);

  always_comb begin
    hue_sel = r2_rain_r;
    val_sel = 8'(scpr_pkg::FULL_VALUE);
    case (cfg.mode)
      scpr_pkg::PM_ANIM_H, scpr_pkg::PM_ANIM_V: begin
        hue_sel = r2_rain_r + r2_toff_r;
      end
      scpr_pkg::PM_SOLID: begin
        hue_sel = cfg.flat_hue;
      end
      scpr_pkg::PM_GRAD1_H, scpr_pkg::PM_GRAD1_V: begin
        hue_sel = cfg.grad_start;
        val_sel = r2_gval_r;
      end
      scpr_pkg::PM_GRAD2_H, scpr_pkg::PM_GRAD2_V: begin
        hue_sel = grad_hue;
      end
      default: begin
        hue_sel = r2_rain_r;
      end
    endcase
    if (!r2_lit_r) begin
      hue_sel = '0;
      val_sel = '0;
    end
  end

  always_comb begin
    r1_valid_nxt  = adv ? tok.valid  : r1_valid_r;
    r2_valid_nxt  = adv ? r1_valid_r : r2_valid_r;
    out_valid_nxt = adv ? r2_valid_r : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r1_valid_r  <= 1'b0;
      r2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      r1_valid_r  <= r1_valid_nxt;
      r2_valid_r  <= r2_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
    if (adv) begin
      r1_lit_r   <= scpr_pkg::HGT_W'(tok.y) < tok.h;
      r1_last_r  <= tok.last;
      r1_neg_r   <= diff[8];
      r1_idx_r   <= 8'(lin_idx);
      r1_rain_r  <= vert ? scpr_pkg::RAINBOW_Y[tok.y] : scpr_pkg::RAINBOW_X[tok.x];
      r1_gval_r  <= vert ? scpr_pkg::VALUE_Y[tok.y] : scpr_pkg::VALUE_X[tok.x];
      r1_toff_r  <= tok.toff;
      r1_p_r     <= scpr_pkg::P_W'(axis) * scpr_pkg::P_W'(diff_mag);

      r2_lit_r   <= r1_lit_r;
      r2_last_r  <= r1_last_r;
      r2_neg_r   <= r1_neg_r;
      r2_idx_r   <= r1_idx_r;
      r2_rain_r  <= r1_rain_r;
      r2_gval_r  <= r1_gval_r;
      r2_toff_r  <= r1_toff_r;
      r2_p_r     <= r1_p_r;
      r2_q0_r    <= scpr_pkg::P_W'(qm >> scpr_pkg::RECIP_SH);

      out_idx_r  <= r2_idx_r;
      out_hue_r  <= hue_sel;
      out_val_r  <= val_sel;
      out_lit_r  <= r2_lit_r;
      out_last_r <= r2_last_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_led_index  = out_idx_r;
  assign out_hue        = out_hue_r;
  assign out_brightness = out_val_r;
  assign out_lit        = out_lit_r;
  assign out_last       = out_last_r;

endmodule
`default_nettype wire
